FILE: rtl/core/rsd_pkg.sv
package rsd_pkg;

   // Span kinds carried on the result channel.
   localparam logic [1:0] KIND_PIXEL     = 2'd0;
   localparam logic [1:0] KIND_TRANSFORM = 2'd1;
   localparam logic [1:0] KIND_END       = 2'd2;

   // Opcode values and ranges of the coded stream.
   localparam logic [7:0] OP_END_ROW     = 8'h00;
   localparam logic [7:0] OP_LIT_FIRST   = 8'h01;
   localparam logic [7:0] OP_LIT_LAST    = 8'h7F;
   localparam logic [7:0] OP_END_SPRITE  = 8'h80;
   localparam logic [7:0] OP_SKIP_FIRST  = 8'h81;
   localparam logic [7:0] OP_SKIP_LAST   = 8'hBF;
   localparam logic [7:0] OP_TRANSFORM   = 8'hC0;
   localparam logic [7:0] OP_RUN_COUNTED = 8'hC1;
   localparam logic [7:0] SKIP_BASE      = 8'h80;
   localparam logic [7:0] RUN_BASE       = 8'hC0;

   // Transform value byte decoding.
   localparam int         XF_ENABLE_BIT  = 6;
   localparam logic [4:0] XF_TYPE_OFFSET = 5'd2;
   localparam logic [4:0] XF_TYPE_MAX    = 5'd15;

   // Configuration register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [15:0] RESET_WIDTH  = 16'd64;
   localparam logic [15:0] RESET_HEIGHT = 16'd64;

   // Span command queue between parser and clipper.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] row;
      logic [15:0] column;
      logic [7:0]  length;
      logic [7:0]  pixel;
      logic [3:0]  xf;
   } span_cmd_type;

   typedef struct packed {
      logic push;
      logic finished;
   } front_status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/rsd_front.sv
module rsd_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_code_byte,
   input  logic                      req_last_byte,
   input  rsd_pkg::queue_status_type qstat,
   output rsd_pkg::span_cmd_type     push_cmd,
   output rsd_pkg::front_status_type fstat
);

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_LITERAL,
      PH_RUNPIX,
      PH_RUNCOUNT,
      PH_XFVALUE,
      PH_XFCOUNT
   } phase_type;

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   phase_type             phase_ff, phase_in;
   logic [6:0]            lit_ff, lit_in;
   logic [7:0]            run_ff, run_in;
   logic [7:0]            xfb_ff, xfb_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  fin_ff, fin_in;

   logic                  take;
   logic [7:0]            adv;
   logic [COORD_BITS:0]   col_sum;
   logic [COORD_BITS-1:0] col_sat;
   logic [COORD_BITS-1:0] row_sat;
   logic [7:0]            xf_v;
   logic [7:0]            xf_c;
   logic [4:0]            xf_type;
   logic                  xf_ok;
   logic                  emit;
   rsd_pkg::span_cmd_type cmd;

   assign req_stall = qstat.full;
   assign take      = req_valid && !req_stall;

   // Column advance of the current byte, shared by every span and skip.
   always_comb begin
      adv = 8'd0;
      case (phase_ff)
         PH_LITERAL: adv = 8'd1;
         PH_RUNPIX:  adv = run_ff;
         PH_XFVALUE: adv = {6'd0, req_code_byte[1:0]};
         PH_XFCOUNT: adv = req_code_byte;
         PH_OPCODE: begin
            if (req_code_byte inside {[rsd_pkg::OP_SKIP_FIRST:rsd_pkg::OP_SKIP_LAST]}) begin
               adv = req_code_byte - rsd_pkg::SKIP_BASE;
            end
         end
         default: adv = 8'd0;
      endcase
   end

   assign col_sum = {1'b0, col_ff} + (COORD_BITS+1)'(adv);
   assign col_sat = col_sum[COORD_BITS] ? COORD_MAX : col_sum[COORD_BITS-1:0];
   assign row_sat = (row_ff == COORD_MAX) ? COORD_MAX : row_ff + 1'b1;

   assign xf_v    = (phase_ff == PH_XFVALUE) ? req_code_byte : xfb_ff;
   assign xf_c    = (phase_ff == PH_XFVALUE) ? {6'd0, req_code_byte[1:0]} : req_code_byte;
   assign xf_type = {1'b0, xf_v[5:2]} + rsd_pkg::XF_TYPE_OFFSET;
   assign xf_ok   = xf_v[rsd_pkg::XF_ENABLE_BIT] && (xf_type <= rsd_pkg::XF_TYPE_MAX);

   always_comb begin
      phase_in = phase_ff;
      lit_in   = lit_ff;
      run_in   = run_ff;
      xfb_in   = xfb_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      fin_in   = fin_ff;
      emit     = 1'b0;
      cmd.kind   = rsd_pkg::KIND_PIXEL;
      cmd.row    = 16'(row_ff);
      cmd.column = 16'(col_ff);
      cmd.length = 8'd0;
      cmd.pixel  = 8'd0;
      cmd.xf     = 4'd0;

      if (take && !fin_ff) begin
         case (phase_ff)
            PH_LITERAL: begin
               emit       = 1'b1;
               cmd.length = 8'd1;
               cmd.pixel  = req_code_byte;
               col_in     = col_sat;
               lit_in     = lit_ff - 7'd1;
               if (lit_ff == 7'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_RUNPIX: begin
               phase_in = PH_OPCODE;
               col_in   = col_sat;
               if (run_ff != 8'd0) begin
                  emit       = 1'b1;
                  cmd.length = run_ff;
                  cmd.pixel  = req_code_byte;
               end
            end
            PH_RUNCOUNT: begin
               run_in   = req_code_byte;
               phase_in = PH_RUNPIX;
            end
            PH_XFVALUE, PH_XFCOUNT: begin
               if (phase_ff == PH_XFVALUE) begin
                  xfb_in = req_code_byte;
               end
               if (phase_ff == PH_XFVALUE && req_code_byte[1:0] == 2'd0) begin
                  phase_in = PH_XFCOUNT;
               end else begin
                  phase_in = PH_OPCODE;
                  col_in   = col_sat;
                  if (xf_ok && xf_c != 8'd0) begin
                     emit       = 1'b1;
                     cmd.kind   = rsd_pkg::KIND_TRANSFORM;
                     cmd.length = xf_c;
                     cmd.xf     = xf_type[3:0];
                  end
               end
            end
            default: begin
               phase_in = PH_OPCODE;
               case (req_code_byte) inside
                  rsd_pkg::OP_END_ROW: begin
                     row_in = row_sat;
                     col_in = '0;
                  end
                  [rsd_pkg::OP_LIT_FIRST:rsd_pkg::OP_LIT_LAST]: begin
                     lit_in   = req_code_byte[6:0];
                     phase_in = PH_LITERAL;
                  end
                  rsd_pkg::OP_END_SPRITE: begin
                     fin_in   = 1'b1;
                     emit     = 1'b1;
                     cmd.kind = rsd_pkg::KIND_END;
                  end
                  [rsd_pkg::OP_SKIP_FIRST:rsd_pkg::OP_SKIP_LAST]: begin
                     col_in = col_sat;
                  end
                  rsd_pkg::OP_TRANSFORM: begin
                     phase_in = PH_XFVALUE;
                  end
                  rsd_pkg::OP_RUN_COUNTED: begin
                     phase_in = PH_RUNCOUNT;
                  end
                  default: begin
                     run_in   = req_code_byte - rsd_pkg::RUN_BASE;
                     phase_in = PH_RUNPIX;
                  end
               endcase
            end
         endcase

         // The final byte closes the sprite; a pending operation is dropped.
         if (req_last_byte) begin
            fin_in   = 1'b1;
            phase_in = PH_OPCODE;
            if (!emit) begin
               emit       = 1'b1;
               cmd.kind   = rsd_pkg::KIND_END;
               cmd.row    = 16'(row_in);
               cmd.column = 16'(col_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         lit_ff   <= '0;
         run_ff   <= '0;
         xfb_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         lit_ff   <= lit_in;
         run_ff   <= run_in;
         xfb_ff   <= xfb_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         fin_ff   <= fin_in;
      end
   end

   assign push_cmd       = cmd;
   assign fstat.push     = emit;
   assign fstat.finished = fin_ff;

endmodule

FILE: rtl/core/rsd_queue.sv
module rsd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rsd_pkg::span_cmd_type     push_cmd,
   input  logic                      pop,
   output rsd_pkg::span_cmd_type     head_cmd,
   output rsd_pkg::queue_status_type qstat
);

   localparam int CNT_BITS = rsd_pkg::QUEUE_PTR_BITS + 1;

   rsd_pkg::span_cmd_type entry_ff [rsd_pkg::QUEUE_DEPTH];
   logic [rsd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]                count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd    = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_BITS'(rsd_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

FILE: rtl/core/rsd_back.sv
module rsd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rsd_pkg::span_cmd_type     head_cmd,
   input  rsd_pkg::queue_status_type qstat,
   output logic                      pop,
   input  logic [15:0]               sprite_width,
   input  logic [15:0]               sprite_height,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_span_kind,
   output logic [15:0]               rsp_row,
   output logic [15:0]               rsp_column_start,
   output logic [7:0]                rsp_span_length,
   output logic [7:0]                rsp_pixel_value,
   output logic [3:0]                rsp_transform_code,
   output logic                      rsp_clipped
);

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [15:0] row_ff, col_ff;
   logic [7:0]  len_ff, pix_ff;
   logic [3:0]  xf_ff;
   logic        clip_ff;

   logic        inside_area;
   logic [15:0] room;
   logic [7:0]  vis;

   assign pop = !qstat.empty && (!valid_ff || !rsp_stall);

   // Clip the span to the configured area.
   assign inside_area = (head_cmd.row < sprite_height) && (head_cmd.column < sprite_width);
   assign room        = sprite_width - head_cmd.column;

   always_comb begin
      vis = 8'd0;
      if (inside_area) begin
         vis = ({8'd0, head_cmd.length} < room) ? head_cmd.length : room[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= head_cmd.kind;
         row_ff  <= head_cmd.row;
         col_ff  <= head_cmd.column;
         len_ff  <= vis;
         pix_ff  <= head_cmd.pixel;
         xf_ff   <= head_cmd.xf;
         clip_ff <= (vis < head_cmd.length);
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_span_kind      = kind_ff;
   assign rsp_row            = row_ff;
   assign rsp_column_start   = col_ff;
   assign rsp_span_length    = len_ff;
   assign rsp_pixel_value    = pix_ff;
   assign rsp_transform_code = xf_ff;
   assign rsp_clipped        = clip_ff;

endmodule

FILE: rtl/core/rle_sprite_span_decoder.sv
// Path: the parser writes the span command of an accepted word into the span queue, and
// the clipper moves it from there into the result register that drives the result port.
// Throughput: one word per cycle while req_stall is low.
// A stalled result holds the queue; req_stall rises once both queue entries are taken.
// Reset is synchronous and active high: the parser returns to the opcode phase at row 0,
// column 0, the queue and output register empty, and both size registers return to 64.
module rle_sprite_span_decoder #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_span_kind,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_column_start,
   output logic [7:0]  rsp_span_length,
   output logic [7:0]  rsp_pixel_value,
   output logic [3:0]  rsp_transform_code,
   output logic        rsp_clipped,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Sprite size registers. Width sits at byte address 0, height at 4.
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rsd_pkg::RESET_WIDTH;
         height_ff <= rsd_pkg::RESET_HEIGHT;
      end else if (csr_write) begin
         if (csr_paddr[2] == rsd_pkg::REG_WIDTH) begin
            width_ff <= csr_pwdata[15:0];
         end else begin
            height_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == rsd_pkg::REG_HEIGHT) ? {16'd0, height_ff}
                                                             : {16'd0, width_ff};

   // The parser consumes one word per cycle while the queue has room, tracks row
   // and column, and turns each word into at most one span command. Commands wait
   // in a short queue so the parser keeps running while the result side is stalled.
   rsd_pkg::span_cmd_type     push_cmd;
   rsd_pkg::span_cmd_type     head_cmd;
   rsd_pkg::front_status_type fstat;
   rsd_pkg::queue_status_type qstat;
   logic                      pop;

   rsd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_byte (req_code_byte),
      .req_last_byte (req_last_byte),
      .qstat         (qstat),
      .push_cmd      (push_cmd),
      .fstat         (fstat)
   );

   rsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fstat.push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // The clipper cuts each span to the configured area and registers the
   // result word. A span starting outside the area leaves with length zero and,
   // unless it is an end record, with the clipped flag set.
   rsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_cmd           (head_cmd),
      .qstat              (qstat),
      .pop                (pop),
      .sprite_width       (width_ff),
      .sprite_height      (height_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_span_kind      (rsp_span_kind),
      .rsp_row            (rsp_row),
      .rsp_column_start   (rsp_column_start),
      .rsp_span_length    (rsp_span_length),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_transform_code (rsp_transform_code),
      .rsp_clipped        (rsp_clipped)
   );

   // The parser never writes a span into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fstat.push |-> !qstat.full)
      else $error("span queue overflow");

   // Once the sprite has ended, no further span is produced.
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      fstat.finished |-> !fstat.push)
      else $error("span produced after end of sprite");

   // The end record carries only its position.
   a_end_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_kind == rsd_pkg::KIND_END) |->
         (rsp_span_length == 8'd0 && !rsp_clipped &&
          rsp_pixel_value == 8'd0 && rsp_transform_code == 4'd0))
      else $error("end record with span payload");

endmodule

FILE: verif/rsd_checker.sv
`timescale 1ns / 1ps

module rsd_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_last_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_span_kind,
   input  logic [15:0] rsp_row,
   input  logic [15:0] rsp_column_start,
   input  logic [7:0]  rsp_span_length,
   input  logic [7:0]  rsp_pixel_value,
   input  logic [3:0]  rsp_transform_code,
   input  logic        rsp_clipped,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,

   output int unsigned spans_pending,
   output int unsigned spans_checked,
   output int unsigned fail_count
);

   typedef enum logic [2:0] {
      AWAIT_OPCODE,
      AWAIT_LITERAL,
      AWAIT_RUN_PIXEL,
      AWAIT_RUN_COUNT,
      AWAIT_XF_VALUE,
      AWAIT_XF_COUNT
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] row;
      logic [15:0] column;
      logic [7:0]  length;
      logic [7:0]  pixel;
      logic [3:0]  xf;
      logic        clipped;
   } span_word_type;

   span_word_type   expected_spans[$];
   parse_phase_type phase;
   logic [6:0]      literals_left;
   logic [7:0]      run_length;
   logic [7:0]      xf_value;
   logic [15:0]     column_pos;
   logic [15:0]     row_pos;
   logic            sprite_done;
   logic [15:0]     width_reg;
   logic [15:0]     height_reg;

   // Positions stop at the top of the coordinate range instead of wrapping.
   function automatic logic [15:0] saturating_add(input logic [15:0] base,
                                                  input logic [7:0] step);
      logic [16:0] sum;
      sum = {1'b0, base} + {9'd0, step};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   task automatic push_span(input logic [1:0] kind, input logic [7:0] len,
                            input logic [7:0] pixel, input logic [3:0] xf);
      span_word_type span;
      logic [15:0] room;
      logic [15:0] visible;
      visible = 16'd0;
      if (row_pos < height_reg && column_pos < width_reg) begin
         room = width_reg - column_pos;
         visible = ({8'd0, len} < room) ? {8'd0, len} : room;
      end
      span = '{kind, row_pos, column_pos, visible[7:0], pixel, xf,
               visible < {8'd0, len}};
      expected_spans.push_back(span);
      column_pos = saturating_add(column_pos, len);
   endtask

   task automatic push_end_record();
      span_word_type span;
      span = '{rsd_pkg::KIND_END, row_pos, column_pos, 8'd0, 8'd0, 4'd0, 1'b0};
      expected_spans.push_back(span);
   endtask

   // A disabled or out-of-range transform type only moves the column.
   task automatic finish_transform(input logic [7:0] count, output bit emitted);
      logic [4:0] xf_type;
      xf_type = {1'b0, xf_value[5:2]} + rsd_pkg::XF_TYPE_OFFSET;
      emitted = 1'b0;
      phase = AWAIT_OPCODE;
      if (xf_value[rsd_pkg::XF_ENABLE_BIT] && xf_type <= rsd_pkg::XF_TYPE_MAX) begin
         if (count != 8'd0) begin
            push_span(rsd_pkg::KIND_TRANSFORM, count, 8'd0, xf_type[3:0]);
            emitted = 1'b1;
         end
      end else begin
         column_pos = saturating_add(column_pos, count);
      end
   endtask

   task automatic decode_word(input logic [7:0] code, input logic last);
      bit emitted;
      emitted = 1'b0;
      if (!sprite_done) begin
         case (phase)
            AWAIT_LITERAL: begin
               push_span(rsd_pkg::KIND_PIXEL, 8'd1, code, 4'd0);
               emitted = 1'b1;
               literals_left = literals_left - 7'd1;
               if (literals_left == 7'd0) phase = AWAIT_OPCODE;
            end
            AWAIT_RUN_PIXEL: begin
               phase = AWAIT_OPCODE;
               if (run_length != 8'd0) begin
                  push_span(rsd_pkg::KIND_PIXEL, run_length, code, 4'd0);
                  emitted = 1'b1;
               end
            end
            AWAIT_RUN_COUNT: begin
               run_length = code;
               phase = AWAIT_RUN_PIXEL;
            end
            AWAIT_XF_VALUE: begin
               xf_value = code;
               if (code[1:0] != 2'd0) finish_transform({6'd0, code[1:0]}, emitted);
               else phase = AWAIT_XF_COUNT;
            end
            AWAIT_XF_COUNT: begin
               finish_transform(code, emitted);
            end
            default: begin
               phase = AWAIT_OPCODE;
               if (code == rsd_pkg::OP_END_ROW) begin
                  row_pos = saturating_add(row_pos, 8'd1);
                  column_pos = 16'd0;
               end else if (code <= rsd_pkg::OP_LIT_LAST) begin
                  literals_left = code[6:0];
                  phase = AWAIT_LITERAL;
               end else if (code == rsd_pkg::OP_END_SPRITE) begin
                  sprite_done = 1'b1;
                  push_end_record();
                  emitted = 1'b1;
               end else if (code <= rsd_pkg::OP_SKIP_LAST) begin
                  column_pos = saturating_add(column_pos, code - rsd_pkg::SKIP_BASE);
               end else if (code == rsd_pkg::OP_TRANSFORM) begin
                  phase = AWAIT_XF_VALUE;
               end else if (code == rsd_pkg::OP_RUN_COUNTED) begin
                  phase = AWAIT_RUN_COUNT;
               end else begin
                  run_length = code - rsd_pkg::RUN_BASE;
                  phase = AWAIT_RUN_PIXEL;
               end
            end
         endcase
         // The final word closes the sprite; a pending operation is dropped.
         if (last) begin
            sprite_done = 1'b1;
            phase = AWAIT_OPCODE;
            if (!emitted) push_end_record();
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] expected,
                                input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      span_word_type oldest;
      if (reset) begin
         expected_spans.delete();
         phase = AWAIT_OPCODE;
         literals_left = 7'd0;
         run_length = 8'd0;
         xf_value = 8'd0;
         column_pos = 16'd0;
         row_pos = 16'd0;
         sprite_done = 1'b0;
         width_reg = rsd_pkg::RESET_WIDTH;
         height_reg = rsd_pkg::RESET_HEIGHT;
         spans_checked = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               $error("Span word arrived with none expected (kind %0d, row %0d, column %0d)",
                      rsp_span_kind, rsp_row, rsp_column_start);
               fail_count++;
            end else begin
               oldest = expected_spans.pop_front();
               compare_field("span_kind", 16'(oldest.kind), 16'(rsp_span_kind));
               compare_field("row", oldest.row, rsp_row);
               compare_field("column_start", oldest.column, rsp_column_start);
               compare_field("span_length", 16'(oldest.length), 16'(rsp_span_length));
               compare_field("pixel_value", 16'(oldest.pixel), 16'(rsp_pixel_value));
               compare_field("transform_code", 16'(oldest.xf), 16'(rsp_transform_code));
               compare_field("clipped", 16'(oldest.clipped), 16'(rsp_clipped));
               spans_checked++;
            end
         end
         if (req_valid && !req_stall) decode_word(req_code_byte, req_last_byte);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == rsd_pkg::REG_WIDTH) width_reg = csr_pwdata[15:0];
            else height_reg = csr_pwdata[15:0];
         end
      end
      spans_pending = expected_spans.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sprite span decoder. The checker beside the
// block watches both channels and the register port, keeps its own decoder
// state and compares every span word; this module feeds code words, stalls
// the receiver at random, programs the sprite size and decides pass or fail.
//
// The block finishes a sprite once and stays finished until reset, and reset
// is applied only once, so the whole run is one long sprite. It is split into
// phases at different sprite sizes; between phases the sender goes quiet until
// every expected span word has come back, and only then are the sizes written.
module tb_top;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   // Margin for the span queue and result register, and for words with no span.
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PHASE_WORDS   = 30;

   typedef enum int unsigned {
      END_BY_CODE,
      END_ON_SPAN,
      END_MID_RUN,
      END_ON_ROW
   } ending_type;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_code_byte;
   logic        req_last_byte;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_span_kind;
   logic [15:0] rsp_row;
   logic [15:0] rsp_column_start;
   logic [7:0]  rsp_span_length;
   logic [7:0]  rsp_pixel_value;
   logic [3:0]  rsp_transform_code;
   logic        rsp_clipped;

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned spans_pending;
   int unsigned spans_checked;
   int unsigned fail_count;

   int unsigned cycle_count = 0;
   int unsigned words_sent = 0;
   int unsigned size_settings = 0;
   bit          quiet_sender = 1'b0;

   rle_sprite_span_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_code_byte      (req_code_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_span_kind      (rsp_span_kind),
      .rsp_row            (rsp_row),
      .rsp_column_start   (rsp_column_start),
      .rsp_span_length    (rsp_span_length),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_transform_code (rsp_transform_code),
      .rsp_clipped        (rsp_clipped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   rsd_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a handshake never completes or spans go missing.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Most idle stretches are short; now and then one is long enough to let
   // the span queue fill up or drain completely.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // The receiver stalls at random, with occasional calm stretches where it
   // takes every span word as soon as it appears.
   initial begin
      int unsigned stall_cycles;
      rsp_stall <= 1'b0;
      forever begin
         repeat ($urandom_range(12, 1)) @(posedge clock);
         if ($urandom_range(9, 0) == 0) begin
            repeat ($urandom_range(150, 50)) @(posedge clock);
         end else begin
            stall_cycles = idle_length();
            if (stall_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Offers one code word and holds it until the block takes it. Valid is
   // only lowered when a gap is wanted, so back-to-back words keep it high.
   task automatic send_word(input logic [7:0] code, input logic last = 1'b0);
      int unsigned gap;
      gap = quiet_sender ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Sender pause: nothing is offered until every expected span word is back,
   // then the SETTLE_CYCLES margin covers words still inside the parser.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_sprite_size(input logic [15:0] width, input logic [15:0] height);
      wait_for_idle();
      write_register(rsd_pkg::REG_WIDTH, width);
      write_register(rsd_pkg::REG_HEIGHT, height);
      size_settings++;
      quiet_sender = ($urandom_range(3, 0) == 0);
   endtask

   // One well-formed operation with random content. The end-of-sprite code is
   // never chosen here; it may show up only as pixel, count or transform data.
   task automatic send_random_operation();
      int unsigned pick;
      int unsigned count;
      logic [7:0]  xf_byte;
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         count = ($urandom_range(9, 0) == 0) ? $urandom_range(127, 1) : $urandom_range(6, 1);
         send_word(8'(count));
         repeat (count) send_word(8'($urandom_range(255, 0)));
      end else if (pick < 48) begin
         send_word(8'($urandom_range(255, rsd_pkg::OP_RUN_COUNTED + 1)));
         send_word(8'($urandom_range(255, 0)));
      end else if (pick < 62) begin
         send_word(rsd_pkg::OP_RUN_COUNTED);
         send_word(($urandom_range(7, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 0)));
         send_word(8'($urandom_range(255, 0)));
      end else if (pick < 80) begin
         // Bias toward enabled transforms so that most of them write spans.
         xf_byte = 8'($urandom_range(255, 0));
         if ($urandom_range(3, 0) != 0) xf_byte[rsd_pkg::XF_ENABLE_BIT] = 1'b1;
         send_word(rsd_pkg::OP_TRANSFORM);
         send_word(xf_byte);
         if (xf_byte[1:0] == 2'd0)
            send_word(($urandom_range(7, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 0)));
      end else if (pick < 92) begin
         send_word(8'($urandom_range(rsd_pkg::OP_SKIP_LAST, rsd_pkg::OP_SKIP_FIRST)));
      end else begin
         send_word(rsd_pkg::OP_END_ROW);
      end
   endtask

   task automatic send_random_phase(input int unsigned word_count);
      int unsigned target;
      target = words_sent + word_count;
      while (words_sent < target) send_random_operation();
   endtask

   initial begin
      ending_type ending;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_code_byte <= 8'd0;
      req_last_byte <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= 3'd0;
      csr_pwdata <= 32'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset size of 64 by 64. Literal pixels with
      // extreme values, short runs up to the longest one, a run that crosses
      // the right edge, a zero-length counted run, a maximal counted run that
      // starts on the last column, and transforms: a short count, a count
      // taken from the following word, the highest legal type, and a type
      // past the limit that only skips columns.
      send_word(rsd_pkg::OP_LIT_FIRST + 8'd1);
      send_word(8'h00);
      send_word(8'hFF);
      send_word(rsd_pkg::RUN_BASE + 8'd2);
      send_word(8'hAB);
      send_word(rsd_pkg::RUN_BASE + 8'd63);
      send_word(8'h55);
      send_word(rsd_pkg::OP_END_ROW);
      send_word(rsd_pkg::OP_SKIP_LAST);
      send_word(rsd_pkg::OP_RUN_COUNTED);
      send_word(8'd0);
      send_word(8'h12);
      send_word(rsd_pkg::OP_RUN_COUNTED);
      send_word(8'd255);
      send_word(8'h34);
      send_word(rsd_pkg::OP_END_ROW);
      send_word(rsd_pkg::OP_TRANSFORM);
      send_word(8'h41);           // enabled, type 2, count 1
      send_word(rsd_pkg::OP_TRANSFORM);
      send_word(8'h7F);           // enabled but type 17: columns skipped
      send_word(rsd_pkg::OP_TRANSFORM);
      send_word(8'h40);           // count comes from the next word
      send_word(8'd5);
      send_word(rsd_pkg::OP_TRANSFORM);
      send_word(8'hF7);           // type 15, the largest one written

      // Random phases at narrow, wide, flat and mixed sprite sizes.
      set_sprite_size(16'd1, 16'd65535);
      send_random_phase(PHASE_WORDS);
      set_sprite_size(16'd65535, 16'd1);
      send_random_phase(PHASE_WORDS);
      set_sprite_size(16'd16, 16'd200);
      send_random_phase(PHASE_WORDS);
      repeat (3) begin
         set_sprite_size(16'($urandom_range(300, 1)), 16'($urandom_range(300, 1)));
         send_random_phase(PHASE_WORDS);
      end

      // Column saturation: disabled transforms each skip 255 columns until the
      // column is one run short of the top, a full run then lands exactly on
      // the edge of a maximal sprite, and the next spans start on the top column
      // value, just past the area, and are clipped to nothing.
      set_sprite_size(16'd65535, 16'd65535);
      quiet_sender = 1'b0;
      send_word(rsd_pkg::OP_END_ROW);
      repeat (256) begin
         send_word(rsd_pkg::OP_TRANSFORM);
         send_word(8'h00);
         send_word(8'd255);
      end
      send_word(rsd_pkg::OP_RUN_COUNTED);
      send_word(8'd255);
      send_word(8'h77);
      send_word(rsd_pkg::RUN_BASE + 8'd2);
      send_word(8'h11);
      send_word(rsd_pkg::OP_LIT_FIRST);
      send_word(8'h22);
      send_word(rsd_pkg::OP_TRANSFORM);
      send_word(8'h42);           // enabled, type 2, count 2
      send_word(rsd_pkg::OP_END_ROW);

      // A last random phase on a tall sprite of random width.
      set_sprite_size(16'($urandom_range(300, 1)), 16'd65535);
      send_random_phase(PHASE_WORDS);

      // Close the sprite in one of the ways the stream can end, then offer a
      // few more words that the finished block must swallow without a span.
      ending = ending_type'($urandom_range(3, 0));
      case (ending)
         END_BY_CODE: begin
            send_word(rsd_pkg::OP_END_SPRITE);
         end
         END_ON_SPAN: begin
            send_word(rsd_pkg::RUN_BASE + 8'd3);
            send_word(8'h5A, 1'b1);
         end
         END_MID_RUN: begin
            send_word(rsd_pkg::OP_RUN_COUNTED);
            send_word(8'd9, 1'b1);
         end
         default: begin
            send_word(rsd_pkg::OP_END_ROW, 1'b1);
         end
      endcase
      repeat (3) send_word(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      send_word(8'($urandom_range(255, 0)), 1'b1);
      wait_for_idle();

      $display("Decoded %0d code words over %0d sprite sizes; %0d span words checked.",
               words_sent, size_settings + 1, spans_checked);
      $display("Run covered clipping, zero-length runs, transform types, column saturation, %s.",
               ending.name());
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/rsd_pkg.sv
rtl/core/rsd_front.sv
rtl/core/rsd_queue.sv
rtl/core/rsd_back.sv
rtl/core/rle_sprite_span_decoder.sv
verif/rsd_checker.sv
verif/tb_top.sv
